>>> rtl/core/alarm_timer_slot_table_top_defines.svh
// assertion macros for the alarm timer slot table
`ifndef ALARM_TIMER_SLOT_TABLE_TOP_DEFINES_SVH
`define ALARM_TIMER_SLOT_TABLE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define ATST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ATST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/atst_pkg.sv
// shared types and constants of the alarm timer slot table
package atst_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

  localparam int OWNER_W  = 16;
  localparam int TKIND_W  = 2;
  localparam int TICK_W   = 32;
  localparam int EXPIRY_W = 16;

  localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd80;
  localparam logic [IDX_W:0]      SLOT_END     = (IDX_W + 1)'(SLOT_COUNT);
  localparam logic [FIRE_W-1:0]   FIRE_MAX     = FIRE_W'(MAX_RESULTS);

  typedef enum logic [2:0] {
    ST_TICK    = 3'd0,
    ST_REARM   = 3'd1,
    ST_NEW     = 3'd2,
    ST_FULL    = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [TKIND_W-1:0] tkind;
    logic [TICK_W-1:0]  start;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

endpackage

>>> rtl/core/atst_if.sv
// request, result and configuration channels of the alarm timer slot table
interface atst_req_if import atst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [OWNER_W-1:0] owner_id;
  logic [TKIND_W-1:0] timer_kind;
  logic               request_nonzero;

  modport source (output valid, kind, owner_id, timer_kind, request_nonzero, input ready);
  modport sink   (input valid, kind, owner_id, timer_kind, request_nonzero, output ready);
endinterface

interface atst_rsp_if import atst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               expired_valid;
  logic [OWNER_W-1:0] expired_owner;
  logic [TICK_W-1:0]  tick_value;
  logic               last;

  modport source (output valid, status, expired_valid, expired_owner, tick_value, last,
                  input ready);
  modport sink   (input valid, status, expired_valid, expired_owner, tick_value, last,
                  output ready);
endinterface

interface atst_cfg_if import atst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [EXPIRY_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/alarm_timer_slot_table_top.sv
// alarm timer slot table: slot memory, scan sequencer and result register
//
// channels: req takes one item (tick or arm request), rsp returns result items,
// cfg writes expiry_ticks at any cycle (ready is always high).
// an ignored arm request skips the walk and goes straight to its final result;
// every other item walks all SLOT_COUNT slots of the slot memory through its
// single read port, one read a cycle unless rsp stalls the walk.
// one item is worked on at a time; req.ready is high when the sequencer is
// idle, even while the last result still waits in the output register.
// a tick gives one result per fired slot, or one empty report, last on the
// final one; an arm request gives exactly one result.
// when rsp stalls the walk halts on the next fired slot until the output
// register drains; nothing is dropped.
// reset (synchronous, rst high) frees all slots through their occupied bits,
// clears the tick counter and sets expiry_ticks to 80; there is no
// clearing pass over the memory.
`include "alarm_timer_slot_table_top_defines.svh"

module alarm_timer_slot_table_top import atst_pkg::*; (
  input  logic clk,
  input  logic rst,
  atst_req_if.sink   req,
  atst_rsp_if.source rsp,
  atst_cfg_if.sink   cfg
);

  state_t              state;
  logic [EXPIRY_W-1:0] expiry;
  logic [TICK_W-1:0]   counter;
  logic [SLOT_COUNT-1:0] slot_vld;

  // latched item
  logic               it_arm;
  logic               it_ign;
  logic [OWNER_W-1:0] it_owner;
  logic [TKIND_W-1:0] it_tkind;

  // scan control
  logic [IDX_W:0]     rd_cnt;
  logic               eval_v;
  logic [IDX_W-1:0]   eval_idx;
  logic               match_v;
  logic [IDX_W-1:0]   match_idx;
  logic               free_v;
  logic [IDX_W-1:0]   free_idx;
  logic [FIRE_W-1:0]  fire_cnt;
  logic               pend_v;
  logic [OWNER_W-1:0] pend_owner;

  // output register
  logic               out_valid;
  status_t            out_status;
  logic               out_exp_v;
  logic [OWNER_W-1:0] out_owner;
  logic [TICK_W-1:0]  out_tick;
  logic               out_last;

  slot_t              rdata;
  slot_t              wdata;
  logic               ram_we;
  logic [IDX_W-1:0]   waddr;
  logic [TICK_W-1:0]  age;
  logic               occ;
  logic               fire;
  logic               out_free;
  logic               stall;
  logic               issue;
  logic               scan_done;
  logic               req_acc;

  logic               load;
  status_t            ld_status;
  logic               ld_exp_v;
  logic [OWNER_W-1:0] ld_owner;
  logic               ld_last;

  atst_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign occ      = slot_vld[eval_idx];
  assign age      = counter - rdata.start;
  assign fire     = eval_v && !it_arm && occ &&
                    (age >= {{(TICK_W-EXPIRY_W){1'b0}}, expiry}) && (fire_cnt < FIRE_MAX);
  assign out_free = !out_valid || rsp.ready;
  // a second fired slot waits until the held one can move to the output register
  assign stall     = fire && pend_v && !out_free;
  assign issue     = (state == S_SCAN) && (rd_cnt < SLOT_END) && !stall;
  assign scan_done = (state == S_SCAN) && (rd_cnt == SLOT_END) && !stall;

  // memory is written only after the walk, so no read can see a stale entry
  assign ram_we = (state == S_FINISH) && out_free && it_arm && !it_ign && (match_v || free_v);
  assign waddr  = match_v ? match_idx : free_idx;
  assign wdata  = '{owner: it_owner, tkind: it_tkind, start: counter};

  always_comb begin
    load      = 1'b0;
    ld_status = ST_TICK;
    ld_exp_v  = 1'b0;
    ld_owner  = '0;
    ld_last   = 1'b1;
    if (fire && pend_v && out_free) begin
      load     = 1'b1;
      ld_exp_v = 1'b1;
      ld_owner = pend_owner;
      ld_last  = 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      load = 1'b1;
      if (it_arm) begin
        priority if (it_ign) begin
          ld_status = ST_IGNORED;
        end else if (match_v) begin
          ld_status = ST_REARM;
        end else if (free_v) begin
          ld_status = ST_NEW;
        end else begin
          ld_status = ST_FULL;
        end
      end else begin
        ld_exp_v = pend_v;
        ld_owner = pend_v ? pend_owner : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      expiry    <= EXPIRY_RESET;
      counter   <= '0;
      slot_vld  <= '0;
      eval_v    <= 1'b0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
      rd_cnt    <= '0;
      fire_cnt  <= '0;
      match_v   <= 1'b0;
      free_v    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        expiry <= cfg.data;
      end

      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            it_arm   <= req.kind;
            it_owner <= req.owner_id;
            it_tkind <= req.timer_kind;
            it_ign   <= req.kind && (!req.request_nonzero || (req.owner_id == '0));
            rd_cnt   <= '0;
            fire_cnt <= '0;
            match_v  <= 1'b0;
            free_v   <= 1'b0;
            pend_v   <= 1'b0;
            if (!req.kind) begin
              counter <= counter + 1'b1;
            end
            if (req.kind && (!req.request_nonzero || (req.owner_id == '0))) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_cnt   <= rd_cnt + 1'b1;
            eval_v   <= 1'b1;
            eval_idx <= rd_cnt[IDX_W-1:0];
          end else if (!stall) begin
            eval_v <= 1'b0;
          end
          if (eval_v && !stall) begin
            if (it_arm) begin
              // ascending walk: keep the lowest matching and lowest free slot
              if (!match_v && occ && (rdata.owner == it_owner) && (rdata.tkind == it_tkind)) begin
                match_v   <= 1'b1;
                match_idx <= eval_idx;
              end
              if (!free_v && !occ) begin
                free_v   <= 1'b1;
                free_idx <= eval_idx;
              end
            end else if (fire) begin
              pend_v             <= 1'b1;
              pend_owner         <= rdata.owner;
              slot_vld[eval_idx] <= 1'b0;
              fire_cnt           <= fire_cnt + 1'b1;
            end
          end
          if (scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state  <= S_IDLE;
            pend_v <= 1'b0;
            if (ram_we && !match_v) begin
              slot_vld[free_idx] <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= ld_status;
      out_exp_v  <= ld_exp_v;
      out_owner  <= ld_owner;
      out_tick   <= counter;
      out_last   <= ld_last;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.expired_valid = out_exp_v;
  assign rsp.expired_owner = out_owner;
  assign rsp.tick_value    = out_tick;
  assign rsp.last          = out_last;

  `ATST_ASSERT_NOW(a_pend_tick_only, pend_v, !it_arm, "held fired slot during an arm request")
  `ATST_ASSERT_NOW(a_scan_bound, state == S_SCAN, rd_cnt <= SLOT_END, "slot walk ran past the table")
  `ATST_ASSERT_NEXT(a_finish_emits, (state == S_FINISH) && out_free,
                    (state == S_IDLE) && out_valid && out_last, "final result not loaded")
  `ATST_ASSERT_NEXT(a_tick_only_frees, (state == S_SCAN) && !it_arm,
                    $countones(slot_vld) <= $past($countones(slot_vld)),
                    "tick walk occupied a slot")

endmodule

>>> rtl/core/atst_ram.sv
// generic single-port-write, registered-read ram
module atst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
